// ===== rtl/bbc_pkg.sv =====
`default_nettype none
package bbc_pkg;

	// sample and coefficient formats
	localparam int DataWidth     = 32;
	localparam int SampleWidth   = 32;
	localparam int CoefWidth     = 32;
	localparam int CoefFrac      = 28;
	localparam int AccWidth      = 64;
	localparam int CfgIndexWidth = 3;

	// second multiplier operand carries one extra bit so the low error half is unsigned
	localparam int MulBWidth  = CoefWidth + 1;
	localparam int ProdWidth  = CoefWidth + MulBWidth;
	localparam int ErrHiShift = 32 - CoefFrac;

	typedef enum logic [3:0] {
		ST_MUL_B0,
		ST_MUL_B1,
		ST_ROUND,
		ST_ERR,
		ST_FB1_Y,
		ST_FB1_HI,
		ST_FB1_LO,
		ST_FB2_Y,
		ST_FB2_HI,
		ST_FB2_LO,
		ST_COMMIT
	} step_t;

	typedef struct packed {
		logic  start;
		logic  run;
		logic  stage;
		step_t step;
		logic  fire_out;
	} ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/bbc_mul.sv =====
`default_nettype none
module bbc_mul
	import bbc_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic signed [CoefWidth-1:0] op_a,
	input  wire logic signed [MulBWidth-1:0] op_b,
	output logic signed [ProdWidth-1:0]      prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= ProdWidth'(op_a) * ProdWidth'(op_b);
	end

endmodule
`default_nettype wire

// ===== rtl/bbc_ctrl.sv =====
`default_nettype none
module bbc_ctrl
	import bbc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic out_hold,
	output logic      in_stall,
	output ctrl_t     ctrl
);

	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t state_q;
	step_t  step_q;
	logic   stage_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_MUL_B0;
			stage_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RUN;
						step_q  <= ST_MUL_B0;
						stage_q <= 1'b0;
					end
				end
				S_RUN: begin
					if (step_q == ST_COMMIT) begin
						if (!stage_q) begin
							stage_q <= 1'b1;
							step_q  <= ST_MUL_B0;
						end else if (!out_hold) begin
							// output slot free: word leaves the core
							state_q <= S_IDLE;
						end
					end else begin
						step_q <= step_t'(step_q + 1'b1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall      = (state_q == S_RUN);
	assign ctrl.start    = (state_q == S_IDLE) && in_valid;
	assign ctrl.run      = (state_q == S_RUN);
	assign ctrl.stage    = stage_q;
	assign ctrl.step     = step_q;
	assign ctrl.fire_out = (state_q == S_RUN) && (step_q == ST_COMMIT) && stage_q && !out_hold;

endmodule
`default_nettype wire

// ===== rtl/biquad_bandpass_cascade_unit.sv =====
// Each biquad section runs 11 steps through the single shared 32x33 multiplier, two
// sections per word; in_stall holds off the next word until this one is in the output register.
// A finished word waits in the output register; the core stalls only if it finishes again first.
// Reset (arst_n low, asynchronous) clears coefficients, both sections' state and the handshake.
`default_nettype none
module biquad_bandpass_cascade_unit
	import bbc_pkg::*;
(
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [DataWidth-1:0]     sample_in,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [DataWidth-1:0]          sample_out,
	input  wire logic                            cfg_we,
	input  wire logic        [CfgIndexWidth-1:0] cfg_index,
	input  wire logic        [CoefWidth-1:0]     cfg_data
);

	localparam logic [1:0] CfgB0 = 2'd0;
	localparam logic [1:0] CfgB1 = 2'd1;
	localparam logic [1:0] CfgA1 = 2'd2;
	localparam logic [1:0] CfgA2 = 2'd3;

	localparam int QWidth = AccWidth - CoefFrac + 1;
	localparam logic signed [QWidth-1:0] SatHi = QWidth'((65'sd1 <<< (SampleWidth - 1)) - 1);
	localparam logic signed [QWidth-1:0] SatLo = ~SatHi;

	ctrl_t ctrl;
	logic  out_valid_q;
	logic  out_hold;

	// index 0 is the highpass section, 1 the lowpass section
	logic signed [CoefWidth-1:0] b0_q [2];
	logic signed [CoefWidth-1:0] b1_q [2];
	logic signed [CoefWidth-1:0] a1_q [2];
	logic signed [CoefWidth-1:0] a2_q [2];
	logic        [AccWidth-1:0]  s1_q [2];
	logic        [AccWidth-1:0]  s2_q [2];

	logic signed [SampleWidth-1:0] x_q;
	logic signed [SampleWidth-1:0] y_q;
	logic        [AccWidth-1:0]    acc_q;
	logic        [AccWidth-1:0]    ff0_q;
	logic        [AccWidth-1:0]    err_q;
	logic signed [DataWidth-1:0]   out_q;

	logic signed [CoefWidth-1:0] mul_a;
	logic signed [MulBWidth-1:0] mul_b;
	logic signed [ProdWidth-1:0] prod_s1;
	logic signed [ProdWidth-1:0] prod_asr;
	logic        [AccWidth-1:0]  prod64;
	logic        [AccWidth-1:0]  prod_hi;
	logic        [AccWidth-1:0]  prod_lo;
	logic signed [QWidth-1:0]    rq;
	logic signed [SampleWidth-1:0] y_next;
	logic        [AccWidth-1:0]  y_scaled;

	assign out_hold = out_valid_q && out_stall;

	bbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_hold (out_hold),
		.in_stall (in_stall),
		.ctrl     (ctrl)
	);

	always_comb begin
		mul_a = b0_q[ctrl.stage];
		mul_b = MulBWidth'(x_q);
		case (ctrl.step)
			ST_MUL_B0: begin
				mul_a = b0_q[ctrl.stage];
				mul_b = MulBWidth'(x_q);
			end
			ST_MUL_B1: begin
				mul_a = b1_q[ctrl.stage];
				mul_b = MulBWidth'(x_q);
			end
			ST_ERR: begin
				mul_a = a1_q[ctrl.stage];
				mul_b = MulBWidth'(y_q);
			end
			ST_FB1_Y: begin
				mul_a = a1_q[ctrl.stage];
				mul_b = MulBWidth'($signed(err_q[AccWidth-1:32]));
			end
			ST_FB1_HI: begin
				mul_a = a1_q[ctrl.stage];
				mul_b = $signed({1'b0, err_q[31:0]});
			end
			ST_FB1_LO: begin
				mul_a = a2_q[ctrl.stage];
				mul_b = MulBWidth'(y_q);
			end
			ST_FB2_Y: begin
				mul_a = a2_q[ctrl.stage];
				mul_b = MulBWidth'($signed(err_q[AccWidth-1:32]));
			end
			ST_FB2_HI: begin
				mul_a = a2_q[ctrl.stage];
				mul_b = $signed({1'b0, err_q[31:0]});
			end
			default: begin
				mul_a = b0_q[ctrl.stage];
				mul_b = MulBWidth'(x_q);
			end
		endcase
	end

	bbc_mul u_mul (
		.clk     (clk),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.prod_s1 (prod_s1)
	);

	// upper error half weighs 2^32, scaled down by 2^CoefFrac; lower half floors
	assign prod64   = prod_s1[AccWidth-1:0];
	assign prod_hi  = prod64 << ErrHiShift;
	assign prod_asr = prod_s1 >>> CoefFrac;
	assign prod_lo  = prod_asr[AccWidth-1:0];

	// round half up, then saturate to the sample range
	always_comb begin
		rq = $signed({acc_q[AccWidth-1], acc_q[AccWidth-1:CoefFrac]})
			+ $signed(QWidth'(acc_q[CoefFrac-1]));
		if (rq > SatHi) begin
			y_next = SatHi[SampleWidth-1:0];
		end else if (rq < SatLo) begin
			y_next = SatLo[SampleWidth-1:0];
		end else begin
			y_next = rq[SampleWidth-1:0];
		end
	end

	assign y_scaled = AccWidth'(y_q) << CoefFrac;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				b0_q[i] <= '0;
				b1_q[i] <= '0;
				a1_q[i] <= '0;
				a2_q[i] <= '0;
				s1_q[i] <= '0;
				s2_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index[1:0])
					CfgB0:   b0_q[cfg_index[2]] <= $signed(cfg_data);
					CfgB1:   b1_q[cfg_index[2]] <= $signed(cfg_data);
					CfgA1:   a1_q[cfg_index[2]] <= $signed(cfg_data);
					CfgA2:   a2_q[cfg_index[2]] <= $signed(cfg_data);
					default: b0_q[cfg_index[2]] <= $signed(cfg_data);
				endcase
			end
			if (ctrl.run) begin
				case (ctrl.step)
					ST_ROUND:  s1_q[ctrl.stage] <= prod64 + s2_q[ctrl.stage];
					ST_FB1_Y:  s1_q[ctrl.stage] <= s1_q[ctrl.stage] - prod64;
					ST_FB1_HI: s1_q[ctrl.stage] <= s1_q[ctrl.stage] - prod_hi;
					ST_FB1_LO: s1_q[ctrl.stage] <= s1_q[ctrl.stage] - prod_lo;
					ST_FB2_Y:  s2_q[ctrl.stage] <= ff0_q - prod64;
					ST_FB2_HI: s2_q[ctrl.stage] <= s2_q[ctrl.stage] - prod_hi;
					ST_FB2_LO: s2_q[ctrl.stage] <= s2_q[ctrl.stage] - prod_lo;
					default: ;
				endcase
			end
			if (ctrl.fire_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			x_q <= $signed(sample_in[SampleWidth-1:0]);
		end
		if (ctrl.run) begin
			case (ctrl.step)
				ST_MUL_B1: begin
					ff0_q <= prod64;
					acc_q <= prod64 + s1_q[ctrl.stage];
				end
				ST_ROUND:  y_q   <= y_next;
				ST_ERR:    err_q <= acc_q - y_scaled;
				ST_COMMIT: x_q   <= y_q;
				default: ;
			endcase
		end
		if (ctrl.fire_out) begin
			out_q <= DataWidth'(y_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("core not busy after taking a word");

	a_out_from_lp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctrl.run && ctrl.step == ST_COMMIT && ctrl.stage))
		else $error("output word not from lowpass commit");

	a_lp_after_hp: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.run && ctrl.step == ST_MUL_B0 && ctrl.stage)
		|-> $past(ctrl.run && ctrl.step == ST_COMMIT && !ctrl.stage))
		else $error("lowpass section started without highpass commit");

endmodule
`default_nettype wire
